[sv/escape_time_fractal_pixel_assert.svh]
// Assertion helpers for the escape-time pixel engine.
// Both macros sample on clk_i and are off while rst_ni is low.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("escape_time_fractal_pixel: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ETF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("escape_time_fractal_pixel: next-cycle check failed");

`endif

[sv/etf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package etf_pkg;

  localparam int SPAN_W     = 13;
  localparam int LIMIT_W    = 10;
  localparam int Q_W        = 32;
  localparam int FRAC_BITS  = 28;
  localparam int QUOT_W     = 30;
  localparam int PROD_W     = 2 * Q_W;
  localparam int SQ_W       = PROD_W - FRAC_BITS;
  localparam int COLOR_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int DIV_CNT_W  = 5;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUOT_W - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 2'd2;

  localparam logic [SPAN_W-1:0]  WIDTH_RESET  = 13'd1433;
  localparam logic [SPAN_W-1:0]  HEIGHT_RESET = 13'd1024;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 10'd100;

  // Plane constants in signed Q4.28.
  localparam logic signed [Q_W-1:0] CX_START = -32'sd671088640;
  localparam logic signed [Q_W-1:0] ONE_Q    = 32'sd268435456;
  localparam logic [SQ_W:0]         FOUR_Q   = 37'd1073741824;

  // Escape gradient, {red, green, blue}.
  localparam logic [3*COLOR_W-1:0] PALETTE [16] = '{
    24'h421E0F, 24'h19071A, 24'h09012F, 24'h040449,
    24'h000764, 24'h0C2C8A, 24'h1852B1, 24'h397DD1,
    24'h86B5E5, 24'hD3ECF8, 24'hF1E9BF, 24'hF8C95F,
    24'hFFAA00, 24'hCC8000, 24'h995700, 24'h6A3403
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_COORD,
    ST_MUL,
    ST_CHK,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic set_coord;
    logic mul;
    logic update;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic escaped;
    logic last_iter;
  } dp_status_t;

endpackage

`default_nettype wire

[sv/escape_time_fractal_pixel.sv]
// Each pixel goes through the 30-step serial coordinate dividers and then,
// unless the iteration limit is zero, the multiply-then-update loop; the engine
// takes a new pixel only once it is back in idle, after the last result is loaded.
// A finished result waits in the output register while the next pixel starts.
// Reset (rst_ni low, asynchronous) idles the engine and reloads 1433, 1024, 100.
`timescale 1ns / 1ps
`default_nettype none

module escape_time_fractal_pixel
  import etf_pkg::*;
#(
  parameter int COORD_BITS      = 12,
  parameter int PALETTE_ENTRIES = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [COORD_BITS-1:0] pixel_column_i,
  input  wire logic [COORD_BITS-1:0] pixel_row_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [COLOR_W-1:0]    red_o,
  output logic      [COLOR_W-1:0]    green_o,
  output logic      [COLOR_W-1:0]    blue_o,
  output logic      [LIMIT_W-1:0]    escape_count_o,
  output logic                       inside_set_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  etf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  etf_dp #(
    .COORD_BITS      (COORD_BITS),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_column_i (pixel_column_i),
    .pixel_row_i    (pixel_row_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .escape_count_o (escape_count_o),
    .inside_set_o   (inside_set_o)
  );

endmodule

`default_nettype wire

[sv/etf_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per step. The dividend is given as a
// high part that is already below the divisor and a low part that is
// shifted in over QUOT_W steps; the low part's register then holds the
// quotient.
module etf_div
  import etf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              load_i,
  input  wire logic              step_i,
  input  wire logic [SPAN_W-1:0] hi_i,
  input  wire logic [QUOT_W-1:0] lo_i,
  input  wire logic [SPAN_W-1:0] divisor_i,
  output logic      [QUOT_W-1:0] quotient_o
);

  logic [SPAN_W-1:0] rem_q, rem_d;
  logic [QUOT_W-1:0] acc_q, acc_d;
  logic [SPAN_W:0]   rem_shift;
  logic [SPAN_W:0]   rem_diff;
  logic              fits;

  always_comb begin
    rem_shift = {rem_q, acc_q[QUOT_W-1]};
    rem_diff  = rem_shift - {1'b0, divisor_i};
    fits      = (rem_shift >= {1'b0, divisor_i});
    rem_d     = rem_q;
    acc_d     = acc_q;
    if (load_i) begin
      rem_d = hi_i;
      acc_d = lo_i;
    end else if (step_i) begin
      rem_d = fits ? rem_diff[SPAN_W-1:0] : rem_shift[SPAN_W-1:0];
      acc_d = {acc_q[QUOT_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign quotient_o = acc_q;

endmodule

`default_nettype wire

[sv/etf_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module etf_dp
  import etf_pkg::*;
#(
  parameter int COORD_BITS      = 12,
  parameter int PALETTE_ENTRIES = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [COORD_BITS-1:0] pixel_column_i,
  input  wire logic [COORD_BITS-1:0] pixel_row_i,
  input  wire ctrl_cmd_t             cmd_i,
  output dp_status_t                 status_o,
  output logic      [COLOR_W-1:0]    red_o,
  output logic      [COLOR_W-1:0]    green_o,
  output logic      [COLOR_W-1:0]    blue_o,
  output logic      [LIMIT_W-1:0]    escape_count_o,
  output logic                       inside_set_o
);

  localparam int EXT_W = (COORD_BITS > SPAN_W) ? COORD_BITS : SPAN_W;
  localparam int PAL_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [PAL_W-1:0] PAL_LAST = PAL_W'(PALETTE_ENTRIES - 1);

  // Configuration registers.
  logic [SPAN_W-1:0]  width_q, height_q;
  logic [LIMIT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      limit_q  <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:     width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT:    height_q <= cfg_data_i;
        CFG_ITERATION_LIMIT: limit_q  <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Coordinate mapping: saturate, then scale through the serial dividers.
  logic [SPAN_W-1:0] span_w, span_h;
  logic [EXT_W-1:0]  col_ext, row_ext;
  logic [SPAN_W-1:0] col_sat, row_sat;
  logic [SPAN_W+2:0] col_x7;
  logic [SPAN_W-1:0] cx_hi, cy_hi;
  logic [QUOT_W-1:0] cx_lo, cy_lo;
  logic [QUOT_W-1:0] cx_quot, cy_quot;

  always_comb begin
    span_w  = (width_q >= 13'd2) ? width_q - 13'd1 : 13'd1;
    span_h  = (height_q >= 13'd2) ? height_q - 13'd1 : 13'd1;
    col_ext = EXT_W'(pixel_column_i);
    row_ext = EXT_W'(pixel_row_i);
    col_sat = (col_ext > EXT_W'(span_w)) ? span_w : col_ext[SPAN_W-1:0];
    row_sat = (row_ext > EXT_W'(span_h)) ? span_h : row_ext[SPAN_W-1:0];
    // col * 3.5 * 2^28 split at bit 30 into a part below the divisor and the rest.
    col_x7  = ({3'b000, col_sat} << 3) - {3'b000, col_sat};
    cx_hi   = col_x7[SPAN_W+2:3];
    cx_lo   = {col_x7[2:0], 27'd0};
    cy_hi   = {1'b0, row_sat[SPAN_W-1:1]};
    cy_lo   = {row_sat[0], 29'd0};
  end

  etf_div u_div_x (
    .clk_i      (clk_i),
    .load_i     (cmd_i.load),
    .step_i     (cmd_i.div_step),
    .hi_i       (cx_hi),
    .lo_i       (cx_lo),
    .divisor_i  (span_w),
    .quotient_o (cx_quot)
  );

  etf_div u_div_y (
    .clk_i      (clk_i),
    .load_i     (cmd_i.load),
    .step_i     (cmd_i.div_step),
    .hi_i       (cy_hi),
    .lo_i       (cy_lo),
    .divisor_i  (span_h),
    .quotient_o (cy_quot)
  );

  // Iteration datapath: the squares and cross product are registered, then the escape test and update use them.
  logic signed [Q_W-1:0]    cx_q, cy_q, x_q, y_q;
  logic signed [PROD_W-1:0] prod_xx, prod_yy, prod_xy;
  logic        [SQ_W-1:0]   sq_x_q, sq_y_q;
  logic        [Q_W-1:0]    xy_q;
  logic        [SQ_W:0]     mag_sum;
  logic        [LIMIT_W-1:0] it_q;
  logic        [PAL_W-1:0]  pal_q;
  logic        [3:0]        pal_idx;
  logic                     in_set;

  assign prod_xx = x_q * x_q;
  assign prod_yy = y_q * y_q;
  assign prod_xy = x_q * y_q;
  assign mag_sum = {1'b0, sq_x_q} + {1'b0, sq_y_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= '0;
      y_q   <= '0;
      it_q  <= '0;
      pal_q <= '0;
    end else if (cmd_i.update) begin
      x_q   <= $signed(sq_x_q[Q_W-1:0] - sq_y_q[Q_W-1:0] + cx_q);
      y_q   <= $signed(xy_q + cy_q);
      it_q  <= it_q + 10'd1;
      pal_q <= (pal_q == PAL_LAST) ? '0 : pal_q + PAL_W'(1);
    end
    if (cmd_i.set_coord) begin
      cx_q <= CX_START + $signed({2'b00, cx_quot});
      cy_q <= ONE_Q - $signed({2'b00, cy_quot});
    end
    if (cmd_i.mul) begin
      // Floor to Q4.28 is the arithmetic shift; 2xy drops one bit less.
      sq_x_q <= prod_xx[PROD_W-1:FRAC_BITS];
      sq_y_q <= prod_yy[PROD_W-1:FRAC_BITS];
      xy_q   <= prod_xy[FRAC_BITS+Q_W-2:FRAC_BITS-1];
    end
  end

  assign status_o.limit_zero = (limit_q == '0);
  assign status_o.escaped    = (mag_sum > FOUR_Q);
  assign status_o.last_iter  = ((it_q + 10'd1) == limit_q);

  // Result register.
  assign pal_idx = 4'(pal_q);
  assign in_set  = (it_q >= limit_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      red_o          <= in_set ? '0 : PALETTE[pal_idx][23:16];
      green_o        <= in_set ? '0 : PALETTE[pal_idx][15:8];
      blue_o         <= in_set ? '0 : PALETTE[pal_idx][7:0];
      escape_count_o <= it_q;
      inside_set_o   <= in_set;
    end
  end

endmodule

`default_nettype wire

[sv/etf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module etf_ctrl
  import etf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_LAST) begin
          state_d = ST_COORD;
        end
      end
      ST_COORD: begin
        cmd_o.set_coord = 1'b1;
        state_d         = status_i.limit_zero ? ST_FIN : ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_CHK;
      end
      ST_CHK: begin
        if (status_i.escaped) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.update = 1'b1;
          state_d      = status_i.last_iter ? ST_FIN : ST_MUL;
        end
      end
      ST_FIN: begin
        // The result register is free when empty or being emptied this cycle.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[sv/etf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "escape_time_fractal_pixel_assert.svh"

module etf_checker #(
  parameter int COORD_BITS = 12
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  cfg_valid_i,
  input wire logic                  cfg_ready_o,
  input wire logic [1:0]            cfg_index_i,
  input wire logic [12:0]           cfg_data_i,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic [COORD_BITS-1:0] pixel_column_i,
  input wire logic [COORD_BITS-1:0] pixel_row_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [7:0]            red_o,
  input wire logic [7:0]            green_o,
  input wire logic [7:0]            blue_o,
  input wire logic [9:0]            escape_count_o,
  input wire logic                  inside_set_o
);

  logic [34:0] out_bits;

  assign out_bits = {red_o, green_o, blue_o, escape_count_o, inside_set_o};

  // A stalled result stays offered.
  `ETF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result does not change.
  `ETF_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_bits))

  // Pixels inside the set are black.
  `ETF_ASSERT_SAME(a_inside_black, out_valid_o && inside_set_o, red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0)

  // The engine works on one pixel at a time, so it is busy right after taking one.
  `ETF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind escape_time_fractal_pixel etf_checker #(.COORD_BITS(COORD_BITS)) u_etf_checker (.*);

`default_nettype wire

[sim/escape_time_fractal_pixel_tb.sv]
`timescale 1ns / 1ps

module escape_time_fractal_pixel_tb;
  import etf_pkg::*;

  localparam int COORD_BITS   = 12;
  localparam int SHADE_COUNT  = 16;
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 2 * 1023 + 40;
  localparam int TIMEOUT_NS   = 40_000_000;
  localparam int Q_FRAC       = 28;
  localparam int RANDOM_PHASES    = 8;
  localparam int PIXELS_PER_PHASE = 120;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Plane geometry in Q4.28, held at 64 bits so that products stay exact.
  localparam longint          PLANE_LEFT       = -64'sd671088640;
  localparam longint unsigned PLANE_WIDTH      = 64'd939524096;
  localparam longint unsigned PLANE_HEIGHT     = 64'd536870912;
  localparam longint          PLANE_TOP        = 64'sd268435456;
  localparam longint          ESCAPE_RADIUS_SQ = 64'sd1073741824;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [LIMIT_W-1:0] count;
    logic               in_set;
  } pixel_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [COORD_BITS-1:0] pixel_column_i = '0;
  logic [COORD_BITS-1:0] pixel_row_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [COLOR_W-1:0]    red_o;
  logic [COLOR_W-1:0]    green_o;
  logic [COLOR_W-1:0]    blue_o;
  logic [LIMIT_W-1:0]    escape_count_o;
  logic                  inside_set_o;

  // Register mirror, starting from the values the block loads at reset.
  int unsigned cfg_width  = 1433;
  int unsigned cfg_height = 1024;
  int unsigned cfg_limit  = 100;

  pixel_t expected_pixels[$];
  int     pixels_sent      = 0;
  int     pixels_checked   = 0;
  int     mismatches       = 0;
  int     settings_applied = 0;
  bit     feeding          = 1'b0;
  bit     idle_inputs      = 1'b0;
  bit     stall_enable     = 1'b0;
  int     stall_hold       = 0;

  escape_time_fractal_pixel DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_column_i (pixel_column_i),
    .pixel_row_i    (pixel_row_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .escape_count_o (escape_count_o),
    .inside_set_o   (inside_set_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  function automatic logic [3*COLOR_W-1:0] gradient_color(input int unsigned idx);
    case (idx)
      0:       return 24'h421E0F;
      1:       return 24'h19071A;
      2:       return 24'h09012F;
      3:       return 24'h040449;
      4:       return 24'h000764;
      5:       return 24'h0C2C8A;
      6:       return 24'h1852B1;
      7:       return 24'h397DD1;
      8:       return 24'h86B5E5;
      9:       return 24'hD3ECF8;
      10:      return 24'hF1E9BF;
      11:      return 24'hF8C95F;
      12:      return 24'hFFAA00;
      13:      return 24'hCC8000;
      14:      return 24'h995700;
      default: return 24'h6A3403;
    endcase
  endfunction

  function automatic pixel_t predict_pixel(input logic [COORD_BITS-1:0] col_in,
                                           input logic [COORD_BITS-1:0] row_in);
    longint unsigned span_w, span_h, col, row;
    longint          cx, cy, zx, zy, zx2, zy2, next_x;
    int unsigned     n;
    bit              escaped;
    pixel_t          p;
    span_w = (cfg_width >= 2) ? cfg_width - 1 : 1;
    span_h = (cfg_height >= 2) ? cfg_height - 1 : 1;
    col = col_in;
    row = row_in;
    if (col > span_w) col = span_w;
    if (row > span_h) row = span_h;
    cx = PLANE_LEFT + $signed((col * PLANE_WIDTH) / span_w);
    cy = PLANE_TOP - $signed((row * PLANE_HEIGHT) / span_h);
    zx = 0;
    zy = 0;
    n = 0;
    escaped = 1'b0;
    while (n < cfg_limit && !escaped) begin
      // Squares are floored back to Q4.28 by the arithmetic shift.
      zx2 = (zx * zx) >>> Q_FRAC;
      zy2 = (zy * zy) >>> Q_FRAC;
      if (zx2 + zy2 > ESCAPE_RADIUS_SQ) begin
        escaped = 1'b1;
      end else begin
        next_x = zx2 - zy2 + cx;
        zy = ((zx * zy * 2) >>> Q_FRAC) + cy;
        zx = next_x;
        n++;
      end
    end
    p.count  = n[LIMIT_W-1:0];
    p.in_set = (n >= cfg_limit);
    if (p.in_set) {p.red, p.green, p.blue} = '0;
    else {p.red, p.green, p.blue} = gradient_color(n % SHADE_COUNT);
    return p;
  endfunction

  function automatic int unsigned random_pause();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  // Mostly inside the image, now and then any 12-bit value so that
  // saturation and every coordinate bit get exercised.
  function automatic logic [COORD_BITS-1:0] pick_coord(input int unsigned extent);
    int unsigned top;
    top = (extent >= 2) ? extent - 1 : 1;
    if (top > 4095) top = 4095;
    if ($urandom_range(0, 9) == 0) return COORD_BITS'($urandom_range(0, 4095));
    return COORD_BITS'($urandom_range(0, top));
  endfunction

  task automatic send_pixel(input logic [COORD_BITS-1:0] col,
                            input logic [COORD_BITS-1:0] row);
    int unsigned gap;
    gap = (idle_inputs && $urandom_range(0, 1) == 1) ? random_pause() : 0;
    if (gap > 0) begin
      if (feeding) begin
        in_valid_i <= 1'b0;
        feeding = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pixel_column_i <= col;
    pixel_row_i    <= row;
    feeding = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_pixels.push_back(predict_pixel(col, row));
    pixels_sent++;
  endtask

  task automatic wait_idle();
    if (feeding) begin
      in_valid_i <= 1'b0;
      feeding = 1'b0;
    end
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high so that back-to-back writes follow without a gap;
  // end_writes lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_IMAGE_WIDTH:     cfg_width = data;
      CFG_IMAGE_HEIGHT:    cfg_height = data;
      CFG_ITERATION_LIMIT: cfg_limit = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_config(input int unsigned w, input int unsigned h,
                              input int unsigned l);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, w[CFG_DATA_W-1:0]);
    write_reg(CFG_IMAGE_HEIGHT, h[CFG_DATA_W-1:0]);
    write_reg(CFG_ITERATION_LIMIT, l[CFG_DATA_W-1:0]);
    end_writes();
    settings_applied++;
  endtask

  task automatic test_default_frame();
    idle_inputs  = 1'b0;
    stall_enable = 1'b0;
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1432, 12'd1023);
    send_pixel(12'd1023, 12'd512);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    wait_idle();
  endtask

  task automatic test_degenerate_sizes();
    // Widths and heights below two fall back to a span of one.
    apply_config(0, 1, 100);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4095, 12'd4095);
    apply_config(1, 0, 100);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    apply_config(8191, 8191, 100);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    wait_idle();
  endtask

  task automatic test_iteration_limits();
    apply_config(1433, 1024, 0);
    send_pixel(12'd1023, 12'd512);
    send_pixel(12'd0, 12'd0);
    apply_config(1433, 1024, 1);
    send_pixel(12'd1023, 12'd512);
    send_pixel(12'd0, 12'd0);
    // Only the low ten data bits reach the iteration limit.
    apply_config(1433, 1024, 13'h1C05);
    send_pixel(12'd1023, 12'd512);
    // A write to the unused index must leave every register alone.
    wait_idle();
    write_reg(CFG_UNUSED, 13'h1FFF);
    end_writes();
    send_pixel(12'd1023, 12'd512);
    apply_config(1433, 1024, 1023);
    send_pixel(12'd1023, 12'd512);
    send_pixel(12'd500, 12'd100);
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned w, h, l;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: begin
          w = $urandom_range(2, 4096);
          h = $urandom_range(2, 4096);
          l = $urandom_range(1, 150);
          idle_inputs  = 1'b0;
          stall_enable = 1'b0;
        end
        1: begin
          w = $urandom_range(2, 4096);
          h = $urandom_range(2, 4096);
          l = $urandom_range(1, 150);
          idle_inputs  = 1'b1;
          stall_enable = 1'b1;
        end
        2: begin
          w = $urandom_range(2, 17);
          h = $urandom_range(2, 17);
          l = $urandom_range(16, 255);
          idle_inputs  = 1'b1;
          stall_enable = 1'b0;
        end
        default: begin
          w = $urandom_range(0, 8191);
          h = $urandom_range(0, 8191);
          l = $urandom_range(1, 100);
          idle_inputs  = 1'b0;
          stall_enable = 1'b1;
        end
      endcase
      apply_config(w, h, l);
      repeat (PIXELS_PER_PHASE) send_pixel(pick_coord(cfg_width), pick_coord(cfg_height));
    end
    // A short run at the deepest iteration limit.
    idle_inputs  = 1'b1;
    stall_enable = 1'b1;
    apply_config($urandom_range(2, 4096), $urandom_range(2, 4096), 1023);
    repeat (12) send_pixel(pick_coord(cfg_width), pick_coord(cfg_height));
    wait_idle();
  endtask

  // Result side: random back-pressure, alternating stall bursts and open runs.
  always @(posedge clk_i) begin
    if (!stall_enable) begin
      out_stall_i <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_hold = $urandom_range(0, 12);
    end else begin
      out_stall_i <= 1'b1;
      stall_hold = random_pause() - 1;
    end
  end

  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {red_o, green_o, blue_o, escape_count_o, inside_set_o};
      pixels_checked++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: result with none pending: r=%0d g=%0d b=%0d count=%0d inside=%0d",
                 $time, got.red, got.green, got.blue, got.count, got.in_set);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: pixel mismatch: expected r=%0d g=%0d b=%0d count=%0d inside=%0d",
                   $time, want.red, want.green, want.blue, want.count, want.in_set);
          $display("%0t:                 actual   r=%0d g=%0d b=%0d count=%0d inside=%0d",
                   $time, got.red, got.green, got.blue, got.count, got.in_set);
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_frame();
    test_degenerate_sizes();
    test_iteration_limits();
    test_random_frames();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d pixels and checked %0d results over %0d register settings,",
             pixels_sent, pixels_checked, settings_applied);
    $display("covering clamped coordinates, degenerate image sizes and limits 0 to 1023.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Timeout with %0d results still pending.", expected_pixels.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
